// ===== src/imudr_pkg.sv =====
`default_nettype none

package imudr_pkg;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Serial divider: 32-bit magnitude over a 16-bit count
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;   // two's complement sum
        logic [15:0] divisor;    // nonzero count
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;       // low 16 bits of the truncated quotient
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== src/imudr_mul.sv =====
`default_nettype none

module imudr_mul (
    input  wire                                       i_clk,
    input  wire  logic signed [imudr_pkg::MUL_A_W-1:0] i_a,
    input  wire  logic signed [imudr_pkg::MUL_B_W-1:0] i_b,
    output logic signed [imudr_pkg::MUL_P_W-1:0]       o_p
);
    import imudr_pkg::*;

    // Registered product, ready the cycle after the operands
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

`default_nettype wire

// ===== src/imudr_div.sv =====
`default_nettype none

module imudr_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire  imudr_pkg::t_div_req  i_req,
    output imudr_pkg::t_div_rsp        o_rsp
);
    import imudr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [15:0]          r_rem;
    logic [31:0]          r_quo;
    logic [15:0]          r_n;
    logic                 r_neg;

    logic [16:0] trial;
    logic        fits;
    logic [16:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[31]};
        fits  = (trial >= {1'b0, r_n});
        n_rem = fits ? (trial - {1'b0, r_n}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg  <= i_req.dividend[31];
                r_quo  <= i_req.dividend[31] ? (32'd0 - i_req.dividend) : i_req.dividend;
                r_n    <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // one quotient bit per cycle, restoring
                r_rem <= n_rem[15:0];
                r_quo <= {r_quo[30:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? (16'd0 - r_quo[15:0]) : r_quo[15:0];

endmodule

`default_nettype wire

// ===== src/imu_dead_reckoning_integrator_unit.sv =====
`default_nettype none
// Integrate request: x and y lanes pass T16, VEL, DIFF, W, MLO, PLO, PHI; rate lane T16, VEL; then OUT.
// Start-calibration, ignored, finishing-short and unused requests go straight to OUT.
// Finishing calibration sample: three DSTART/DWAIT passes of the 32-step divider, then OUT.
// All integrate products go through one shared 33x17 multiplier, one product per cycle.
// Reset (synchronous, active low) clears all integrator and calibration state, sets
// calib_count to 1 and leaves no result pending.

module imu_dead_reckoning_integrator_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // request channel
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [1:0]         i_cmd,
    input  wire  signed [15:0] i_acc_x,
    input  wire  signed [15:0] i_acc_y,
    input  wire  [7:0]         i_gyro_raw,
    input  wire  [15:0]        i_dt,
    // result channel
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [63:0] o_disp_x,
    output logic signed [63:0] o_disp_y,
    output logic signed [63:0] o_heading,
    output logic               o_calibrated,
    // calib_count write channel
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [15:0]        i_cfg_data
);
    import imudr_pkg::*;

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_T16    = 4'd1;
    localparam logic [3:0] ST_VEL    = 4'd2;
    localparam logic [3:0] ST_DIFF   = 4'd3;
    localparam logic [3:0] ST_W      = 4'd4;
    localparam logic [3:0] ST_MLO    = 4'd5;
    localparam logic [3:0] ST_PLO    = 4'd6;
    localparam logic [3:0] ST_PHI    = 4'd7;
    localparam logic [3:0] ST_DSTART = 4'd8;
    localparam logic [3:0] ST_DWAIT  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    // Commands
    localparam logic [1:0] CMD_INTEG = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // Lanes walked by the sequencer
    localparam logic [1:0] LANE_X = 2'd0;
    localparam logic [1:0] LANE_Y = 2'd1;
    localparam logic [1:0] LANE_R = 2'd2;

    logic [3:0]  r_state;
    logic [1:0]  r_lane;

    logic [15:0] r_calib_count;

    // architectural state
    logic [15:0] r_bias_x, r_bias_y, r_bias_rate;
    logic [31:0] r_sum_x, r_sum_y, r_sum_rate;
    logic [15:0] r_sample_counter;
    logic [15:0] r_prev_acc_x, r_prev_acc_y, r_prev_rate;
    logic [63:0] r_vel_x, r_vel_y, r_pos_x, r_pos_y, r_angle_acc;
    logic [63:0] r_pvel_x, r_pvel_y;
    logic        r_done_flag;

    // per-request working registers
    logic [15:0] r_cx, r_cy, r_cr;
    logic [15:0] r_dt;
    logic [63:0] r_d;
    logic [63:0] r_w;

    // result register
    logic        r_out_valid;
    logic [63:0] r_out_disp_x, r_out_disp_y, r_out_heading;
    logic        r_out_cal;

    // request decode
    logic        in_accept;
    logic [15:0] rate16;
    logic [15:0] eff_n;
    logic [15:0] n_counter;
    logic [31:0] n_sum_x, n_sum_y, n_sum_rate;

    // lane datapath
    logic [15:0] va, vp;
    logic [16:0] d17, h17;
    logic [17:0] t18;
    logic [63:0] vel_sel, pvel_sel, pos_sel;
    logic [63:0] prod64;
    logic [63:0] half_d;

    // shared units
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // gyro byte minus 128, sign extended
    assign rate16    = {{8{~i_gyro_raw[7]}}, ~i_gyro_raw[7], i_gyro_raw[6:0]};
    assign eff_n     = (r_calib_count == 16'd0) ? 16'd1 : r_calib_count;
    assign n_counter = r_sample_counter + 16'd1;
    assign n_sum_x    = r_sum_x + {{16{i_acc_x[15]}}, i_acc_x};
    assign n_sum_y    = r_sum_y + {{16{i_acc_y[15]}}, i_acc_y};
    assign n_sum_rate = r_sum_rate + {{16{rate16[15]}}, rate16};

    // Lane selection and the value-plus-half-change term
    always_comb begin
        case (r_lane)
            LANE_X:  begin va = r_cx; vp = r_prev_acc_x; end
            LANE_Y:  begin va = r_cy; vp = r_prev_acc_y; end
            default: begin va = r_cr; vp = r_prev_rate;  end
        endcase
        vel_sel  = (r_lane == LANE_X) ? r_vel_x  : r_vel_y;
        pvel_sel = (r_lane == LANE_X) ? r_pvel_x : r_pvel_y;
        pos_sel  = (r_lane == LANE_X) ? r_pos_x  : r_pos_y;

        d17 = {va[15], va} - {vp[15], vp};
        // halve toward zero: arithmetic shift, round odd negatives up
        h17 = {d17[16], d17[16:1]} + {16'd0, d17[16] & d17[0]};
        t18 = {{2{va[15]}}, va} + {h17[16], h17};

        half_d = {r_d[63], r_d[63:1]};
        prod64 = {{(64 - MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
    end

    // Multiplier operand select
    always_comb begin
        mul_b = {1'b0, r_dt};
        unique case (r_state)
            ST_T16:  mul_a = {{(MUL_A_W - 18){t18[17]}}, t18};
            ST_MLO:  mul_a = {1'b0, r_w[31:0]};
            ST_PLO:  mul_a = {1'b0, r_w[63:32]};
            default: mul_a = '0;
        endcase
    end

    // Divider request
    always_comb begin
        div_req.start   = (r_state == ST_DSTART);
        div_req.divisor = eff_n;
        case (r_lane)
            LANE_X:  div_req.dividend = r_sum_x;
            LANE_Y:  div_req.dividend = r_sum_y;
            default: div_req.dividend = r_sum_rate;
        endcase
    end

    imudr_mul u_mul (
        .i_clk (i_clk),
        .i_a   ($signed(mul_a)),
        .i_b   ($signed(mul_b)),
        .o_p   (mul_p)
    );

    imudr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_count <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_calib_count <= i_cfg_data;
        end
    end

    // Working registers: payload only, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            // bias-corrected values, wrapped to 16 bits
            r_cx <= i_acc_x - r_bias_x;
            r_cy <= i_acc_y - r_bias_y;
            r_cr <= rate16 - r_bias_rate;
            r_dt <= i_dt;
        end
        if (r_state == ST_DIFF) begin
            r_d <= vel_sel - pvel_sel;
        end
        if (r_state == ST_W) begin
            r_w <= vel_sel + half_d + {63'd0, r_d[63] & r_d[0]};
        end
        if (r_state == ST_OUT && (!r_out_valid || !i_out_stall)) begin
            r_out_disp_x  <= r_pos_x;
            r_out_disp_y  <= r_pos_y;
            r_out_heading <= r_angle_acc;
            r_out_cal     <= r_done_flag;
        end
    end

    // Sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_lane           <= LANE_X;
            r_out_valid      <= 1'b0;
            r_bias_x         <= '0;
            r_bias_y         <= '0;
            r_bias_rate      <= '0;
            r_sum_x          <= '0;
            r_sum_y          <= '0;
            r_sum_rate       <= '0;
            r_sample_counter <= '0;
            r_prev_acc_x     <= '0;
            r_prev_acc_y     <= '0;
            r_prev_rate      <= '0;
            r_vel_x          <= '0;
            r_vel_y          <= '0;
            r_pos_x          <= '0;
            r_pos_y          <= '0;
            r_angle_acc      <= '0;
            r_pvel_x         <= '0;
            r_pvel_y         <= '0;
            r_done_flag      <= 1'b0;
        end else begin
            // drop the result once taken
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_lane  <= LANE_X;
                        r_state <= ST_OUT;
                        case (i_cmd)
                            CMD_INTEG: begin
                                r_state <= ST_T16;
                            end
                            CMD_START: begin
                                // clear everything but the biases
                                r_sum_x          <= '0;
                                r_sum_y          <= '0;
                                r_sum_rate       <= '0;
                                r_sample_counter <= '0;
                                r_prev_acc_x     <= '0;
                                r_prev_acc_y     <= '0;
                                r_prev_rate      <= '0;
                                r_vel_x          <= '0;
                                r_vel_y          <= '0;
                                r_pos_x          <= '0;
                                r_pos_y          <= '0;
                                r_angle_acc      <= '0;
                                r_pvel_x         <= '0;
                                r_pvel_y         <= '0;
                                r_done_flag      <= 1'b0;
                            end
                            CMD_SAMPLE: begin
                                // samples after a finished calibration are dropped
                                if (!r_done_flag) begin
                                    r_sum_x          <= n_sum_x;
                                    r_sum_y          <= n_sum_y;
                                    r_sum_rate       <= n_sum_rate;
                                    r_sample_counter <= n_counter;
                                    if (n_counter >= eff_n) begin
                                        r_state <= ST_DSTART;
                                    end
                                end
                            end
                            default: begin
                                // unused command: report state only
                            end
                        endcase
                    end
                end

                ST_T16: begin
                    r_state <= ST_VEL;
                end

                ST_VEL: begin
                    // accumulate the first integral, advance the previous sample
                    case (r_lane)
                        LANE_X: begin
                            r_vel_x      <= r_vel_x + prod64;
                            r_prev_acc_x <= r_cx;
                            r_state      <= ST_DIFF;
                        end
                        LANE_Y: begin
                            r_vel_y      <= r_vel_y + prod64;
                            r_prev_acc_y <= r_cy;
                            r_state      <= ST_DIFF;
                        end
                        default: begin
                            r_angle_acc <= r_angle_acc + prod64;
                            r_prev_rate <= r_cr;
                            r_state     <= ST_OUT;
                        end
                    endcase
                end

                ST_DIFF: begin
                    r_state <= ST_W;
                end

                ST_W: begin
                    if (r_lane == LANE_X) begin
                        r_pvel_x <= r_vel_x;
                    end else begin
                        r_pvel_y <= r_vel_y;
                    end
                    r_state <= ST_MLO;
                end

                ST_MLO: begin
                    r_state <= ST_PLO;
                end

                ST_PLO: begin
                    // low 32 bits of velocity term times ticks
                    if (r_lane == LANE_X) begin
                        r_pos_x <= pos_sel + {16'd0, mul_p[47:0]};
                    end else begin
                        r_pos_y <= pos_sel + {16'd0, mul_p[47:0]};
                    end
                    r_state <= ST_PHI;
                end

                ST_PHI: begin
                    // high half contributes only its low 32 product bits
                    if (r_lane == LANE_X) begin
                        r_pos_x <= pos_sel + {mul_p[31:0], 32'd0};
                        r_lane  <= LANE_Y;
                    end else begin
                        r_pos_y <= pos_sel + {mul_p[31:0], 32'd0};
                        r_lane  <= LANE_R;
                    end
                    r_state <= ST_T16;
                end

                ST_DSTART: begin
                    r_state <= ST_DWAIT;
                end

                ST_DWAIT: begin
                    if (div_rsp.done) begin
                        case (r_lane)
                            LANE_X: begin
                                r_bias_x <= div_rsp.quot;
                                r_lane   <= LANE_Y;
                                r_state  <= ST_DSTART;
                            end
                            LANE_Y: begin
                                r_bias_y <= div_rsp.quot;
                                r_lane   <= LANE_R;
                                r_state  <= ST_DSTART;
                            end
                            default: begin
                                r_bias_rate <= div_rsp.quot;
                                r_done_flag <= 1'b1;
                                r_state     <= ST_OUT;
                            end
                        endcase
                    end
                end

                ST_OUT: begin
                    // hold until the result register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_disp_x     = $signed(r_out_disp_x);
    assign o_disp_y     = $signed(r_out_disp_y);
    assign o_heading    = $signed(r_out_heading);
    assign o_calibrated = r_out_cal;

endmodule

`default_nettype wire

// ===== tb/imu_dead_reckoning_integrator_unit_tb.sv =====
`timescale 1ns / 1ps

module imu_dead_reckoning_integrator_unit_tb;

    // Request commands
    typedef enum logic [1:0] {
        CMD_INTEGRATE  = 2'd0,
        CMD_CAL_START  = 2'd1,
        CMD_CAL_SAMPLE = 2'd2,
        CMD_UNUSED     = 2'd3
    } imu_cmd_e;

    typedef struct packed {
        imu_cmd_e    cmd;
        logic [15:0] acc_x;
        logic [15:0] acc_y;
        logic [7:0]  gyro;
        logic [15:0] dt;
    } imu_item_t;

    typedef struct packed {
        logic [63:0] disp_x;
        logic [63:0] disp_y;
        logic [63:0] heading;
        logic        calibrated;
    } nav_fix_t;

    // Clock, reset and DUT ports; every input starts at a known value
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_cmd = 2'd0;
    logic [15:0] i_acc_x = 16'd0;
    logic [15:0] i_acc_y = 16'd0;
    logic [7:0]  i_gyro_raw = 8'd0;
    logic [15:0] i_dt = 16'd0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data = 16'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_disp_x;
    logic [63:0] o_disp_y;
    logic [63:0] o_heading;
    logic        o_calibrated;
    logic        o_cfg_ready;

    imu_dead_reckoning_integrator_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_acc_x      (i_acc_x),
        .i_acc_y      (i_acc_y),
        .i_gyro_raw   (i_gyro_raw),
        .i_dt         (i_dt),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_disp_x     (o_disp_x),
        .o_disp_y     (o_disp_y),
        .o_heading    (o_heading),
        .o_calibrated (o_calibrated),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Dead-reckoning predictor: its own copy of the integrator and
    // calibration state, advanced once per accepted request.
    // ------------------------------------------------------------------
    logic [15:0] calib_count_q = 16'd1;
    logic [15:0] bias_ax = '0, bias_ay = '0, bias_gz = '0;
    logic [63:0] sum_ax = '0, sum_ay = '0, sum_gz = '0;
    logic [15:0] cal_samples = '0;
    logic [15:0] last_ax = '0, last_ay = '0, last_gz = '0;
    logic [63:0] vel_x = '0, vel_y = '0, pos_x = '0, pos_y = '0, yaw = '0;
    logic [63:0] last_vx = '0, last_vy = '0;
    logic        cal_done = 1'b0;

    function automatic logic [63:0] sext16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Value plus half its change (truncated toward zero), times ticks
    function automatic logic [63:0] trapezoid16(logic [15:0] cur, logic [15:0] prev,
                                                logic [15:0] ticks);
        longint signed a;
        longint signed p;
        longint signed t;
        a = $signed(sext16(cur));
        p = $signed(sext16(prev));
        t = a + (a - p) / 2;
        return t * $signed({48'd0, ticks});
    endfunction

    function automatic logic [63:0] trapezoid64(logic [63:0] cur, logic [63:0] prev,
                                                logic [15:0] ticks);
        logic [63:0]    diff;
        longint signed  half;
        diff = cur - prev;
        half = $signed(diff) / 2;
        return (cur + half) * {48'd0, ticks};
    endfunction

    // Signed sum over a positive count, truncated, low 16 bits kept
    function automatic logic [15:0] mean16(logic [63:0] sum, logic [63:0] n);
        logic [63:0] q;
        if (sum[63]) begin
            q = (-sum) / n;
            q = -q;
        end else begin
            q = sum / n;
        end
        return q[15:0];
    endfunction

    function automatic nav_fix_t dead_reckon_step(imu_item_t it);
        logic [15:0] rate;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cr;
        logic [63:0] n;
        nav_fix_t    fix;
        rate = {8'd0, it.gyro} - 16'd128;
        case (it.cmd)
            CMD_INTEGRATE: begin
                cx = it.acc_x - bias_ax;
                cy = it.acc_y - bias_ay;
                cr = rate - bias_gz;
                vel_x = vel_x + trapezoid16(cx, last_ax, it.dt);
                pos_x = pos_x + trapezoid64(vel_x, last_vx, it.dt);
                last_ax = cx;
                last_vx = vel_x;
                vel_y = vel_y + trapezoid16(cy, last_ay, it.dt);
                pos_y = pos_y + trapezoid64(vel_y, last_vy, it.dt);
                last_ay = cy;
                last_vy = vel_y;
                yaw = yaw + trapezoid16(cr, last_gz, it.dt);
                last_gz = cr;
            end
            CMD_CAL_START: begin
                // Biases survive until the new calibration finishes
                sum_ax = '0; sum_ay = '0; sum_gz = '0;
                cal_samples = '0;
                last_ax = '0; last_ay = '0; last_gz = '0;
                vel_x = '0; vel_y = '0; pos_x = '0; pos_y = '0; yaw = '0;
                last_vx = '0; last_vy = '0;
                cal_done = 1'b0;
            end
            CMD_CAL_SAMPLE: begin
                if (!cal_done) begin
                    n = (calib_count_q == 16'd0) ? 64'd1 : {48'd0, calib_count_q};
                    sum_ax = sum_ax + sext16(it.acc_x);
                    sum_ay = sum_ay + sext16(it.acc_y);
                    sum_gz = sum_gz + sext16(rate);
                    cal_samples = cal_samples + 16'd1;
                    if ({48'd0, cal_samples} >= n) begin
                        bias_ax = mean16(sum_ax, n);
                        bias_ay = mean16(sum_ay, n);
                        bias_gz = mean16(sum_gz, n);
                        cal_done = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        fix.disp_x = pos_x;
        fix.disp_y = pos_y;
        fix.heading = yaw;
        fix.calibrated = cal_done;
        return fix;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them.
    // ------------------------------------------------------------------
    imu_item_t sample_queue[$];
    nav_fix_t  predicted_nav[$];
    imu_item_t held_item;
    int        gap_left = 0;
    int        burst_left = 1;
    int        items_sent = 0;
    int        results_seen = 0;
    int        useful_sent = 0;
    int        fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // Predict the request the block takes at this edge
            if (i_in_valid && !o_in_stall) begin
                predicted_nav.push_back(dead_reckon_step(held_item));
            end
            // Hold a stalled request; otherwise advance to the next one or idle
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0 || sample_queue.size() == 0) begin
                    if (gap_left != 0) gap_left--;
                    i_in_valid <= 1'b0;
                end else begin
                    held_item = sample_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd      <= held_item.cmd;
                    i_acc_x    <= held_item.acc_x;
                    i_acc_y    <= held_item.acc_y;
                    i_gyro_raw <= held_item.gyro;
                    i_dt       <= held_item.dt;
                    if (burst_left <= 1) begin
                        // Now and then a long burst with no gaps at all
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: alternating runs of stall and flow, checks each
    // accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    int stall_left = 0;

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch in result %0d, %s: expected %h, got %h",
                         results_seen, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        nav_fix_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (predicted_nav.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d arrived with no request pending: %h %h %h %b",
                                 results_seen, o_disp_x, o_disp_y, o_heading, o_calibrated);
                end else begin
                    want = predicted_nav.pop_front();
                    compare_field("disp_x", want.disp_x, o_disp_x);
                    compare_field("disp_y", want.disp_y, o_disp_y);
                    compare_field("heading", want.heading, o_heading);
                    compare_field("calibrated", {63'd0, want.calibrated}, {63'd0, o_calibrated});
                end
            end
            // Flip between stall and flow; flow runs are sometimes long
            if (stall_left != 0) begin
                stall_left--;
            end else begin
                i_out_stall <= !i_out_stall;
                if (i_out_stall)
                    stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                             : $urandom_range(0, 40);
                else
                    stall_left = $urandom_range(0, 10);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(input imu_cmd_e cmd, input logic [15:0] ax, input logic [15:0] ay,
                              input logic [7:0] gyro, input logic [15:0] dt, input bit useful);
        imu_item_t it;
        it.cmd   = cmd;
        it.acc_x = ax;
        it.acc_y = ay;
        it.gyro  = gyro;
        it.dt    = dt;
        sample_queue.push_back(it);
        items_sent++;
        if (useful) useful_sent++;
    endtask

    // Drop out only once every request has come back as a result
    task automatic wait_for_drain();
        while (results_seen < items_sent) @(posedge i_clk);
    endtask

    task automatic write_calib_count(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        calib_count_q = value;
    endtask

    function automatic logic [15:0] rand_acc();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($urandom_range(0, 400) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_ticks();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4, 5: return 16'($urandom_range(1, 100));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(9, 48));
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    // One calibration followed by a stretch of integration, with noise mixed in
    task automatic queue_navigation_run();
        int n_cal;
        int n_int;
        if ($urandom_range(0, 7) != 0)
            queue_item(CMD_CAL_START, rand_acc(), rand_acc(), 8'($urandom), rand_ticks(), 1);
        n_cal = (calib_count_q == 16'd0) ? 1 :
                (calib_count_q > 16'd64) ? $urandom_range(1, 6) : int'(calib_count_q);
        if ($urandom_range(0, 5) == 0) n_cal += $urandom_range(1, 2);
        repeat (n_cal) begin
            if ($urandom_range(0, 15) == 0)
                queue_item(($urandom_range(0, 1) == 0) ? CMD_UNUSED : CMD_INTEGRATE,
                           rand_acc(), rand_acc(), 8'($urandom), rand_ticks(), 0);
            queue_item(CMD_CAL_SAMPLE, rand_acc(), rand_acc(), 8'($urandom), rand_ticks(), 1);
        end
        n_int = $urandom_range(3, 30);
        repeat (n_int) begin
            case ($urandom_range(0, 19))
                0: queue_item(CMD_CAL_SAMPLE, rand_acc(), rand_acc(), 8'($urandom),
                              rand_ticks(), 0);
                1: queue_item(CMD_UNUSED, rand_acc(), rand_acc(), 8'($urandom),
                              rand_ticks(), 0);
                default: queue_item(CMD_INTEGRATE, rand_acc(), rand_acc(), 8'($urandom),
                                    rand_ticks(), 1);
            endcase
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Count of one from reset: the first sample finishes calibration
        // with no start request, the next one is ignored
        queue_item(CMD_CAL_SAMPLE, 16'h7FFF, 16'h8000, 8'hFF, 16'hFFFF, 1);
        queue_item(CMD_CAL_SAMPLE, 16'h0001, 16'hFFFF, 8'h00, 16'h0000, 0);
        // Field extremes through the integrator, wrapped corrections, zero ticks
        queue_item(CMD_INTEGRATE, 16'h8000, 16'h7FFF, 8'h00, 16'hFFFF, 1);
        queue_item(CMD_INTEGRATE, 16'h7FFF, 16'h8000, 8'hFF, 16'hFFFF, 1);
        queue_item(CMD_INTEGRATE, 16'h8000, 16'h8000, 8'h00, 16'h0000, 1);
        queue_item(CMD_INTEGRATE, 16'hFFFF, 16'h0001, 8'h80, 16'h0001, 1);
        queue_item(CMD_UNUSED, 16'h7FFF, 16'h8000, 8'hFF, 16'hFFFF, 0);
        // Start clears the integrators but keeps the old biases in use
        queue_item(CMD_CAL_START, 16'h5555, 16'hAAAA, 8'h80, 16'h5555, 1);
        queue_item(CMD_INTEGRATE, 16'h8000, 16'h7FFF, 8'h00, 16'hFFFF, 1);
        queue_item(CMD_CAL_SAMPLE, 16'h8000, 16'h8000, 8'h00, 16'hAAAA, 1);
        wait_for_drain();

        // Zero count behaves as one
        write_calib_count(16'd0);
        queue_item(CMD_CAL_START, 16'h0000, 16'h0000, 8'h80, 16'h0000, 1);
        queue_item(CMD_CAL_SAMPLE, 16'h1234, 16'hEDCB, 8'h55, 16'h0000, 1);
        queue_item(CMD_CAL_SAMPLE, 16'h7FFF, 16'h7FFF, 8'hFF, 16'h0000, 0);
        queue_item(CMD_INTEGRATE, 16'h1000, 16'hF000, 8'hAA, 16'h00FF, 1);
        wait_for_drain();

        // Largest count: samples pile up without finishing
        write_calib_count(16'hFFFF);
        queue_item(CMD_CAL_START, 16'h0000, 16'h0000, 8'h80, 16'h0000, 1);
        queue_item(CMD_CAL_SAMPLE, 16'h8000, 16'h8000, 8'h00, 16'h0000, 1);
        queue_item(CMD_CAL_SAMPLE, 16'h7FFF, 16'h8000, 8'hFF, 16'h0000, 1);
        queue_item(CMD_CAL_SAMPLE, 16'h8000, 16'h7FFF, 8'h00, 16'h0000, 1);
        queue_item(CMD_CAL_SAMPLE, 16'h8000, 16'h8000, 8'h01, 16'h0000, 1);
        queue_item(CMD_CAL_SAMPLE, 16'hC000, 16'h8001, 8'h00, 16'h0000, 1);
        queue_item(CMD_INTEGRATE, 16'h0100, 16'hFF00, 8'h90, 16'h0400, 1);
        wait_for_drain();

        // Count lowered below the counter: the next sample finishes
        write_calib_count(16'd3);
        queue_item(CMD_CAL_SAMPLE, 16'h8000, 16'h8000, 8'h00, 16'h0000, 1);
        queue_item(CMD_INTEGRATE, 16'h4000, 16'hC000, 8'h70, 16'h1000, 1);
        wait_for_drain();

        // Random phases, each under a fresh count
        useful_sent = 0;
        while (useful_sent < 1400) begin
            write_calib_count(pick_count());
            repeat ($urandom_range(2, 5)) queue_navigation_run();
            wait_for_drain();
        end

        repeat (150) @(posedge i_clk);
        if (predicted_nav.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog, several times the slowest correct run
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== imu_dead_reckoning_integrator_unit.f =====
src/imudr_pkg.sv
src/imudr_mul.sv
src/imudr_div.sv
src/imu_dead_reckoning_integrator_unit.sv
tb/imu_dead_reckoning_integrator_unit_tb.sv
